// File: design/sse_pkg.sv
// Shared types, constants and control structures of the stroke slope estimator.
`default_nettype none
package sse_pkg;

    localparam int DEFAULT_START_STRICTNESS = 2;
    localparam int COORD_W = 15;
    localparam int SUM_W = 16;
    localparam int SLOPE_SCALE = 100;
    localparam int DIVIDEND_W = 22;
    localparam int DIV_STEPS = DIVIDEND_W;
    localparam int COUNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic               first_is_min;
        logic               second_is_max;
        logic [COORD_W-1:0] first_end_x;
        logic [COORD_W-1:0] first_end_y;
        logic [COORD_W-1:0] second_begin_x;
        logic [COORD_W-1:0] second_begin_y;
        logic               last_pair;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] slope;
        logic [1:0]              strictness_used;
    } out_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SELECT,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic accumulate;
        logic load_div;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

// File: design/stroke_slope_estimator_core.sv
// Top level of the stroke slope estimator: controller and datapath.
//
// Input transfers on s_valid/s_ready carry one pair of neighbouring stroke
// extrema each. While a list is being gathered a pair is taken every cycle
// and added into all strictness sets at once. The pair flagged last_pair
// closes the list: the block then stops taking pairs, selects the strictest
// set whose refused sum is within three quarters of its accepted sum, and
// divides 100 times its dx sum by its dy sum in a restoring divider that
// produces one quotient bit per cycle.
// The result transfer on m_valid/m_ready appears once the last pair has
// passed the selection state, the divider steps and the load into the
// output register, and s_ready rises again in that same cycle. If the
// receiver stalls, the result waits in the output register and the next list
// is gathered meanwhile; only a further last pair then waits for the register
// to empty. Reset clears all sets, the state machine and the output valid.
`default_nettype none
module stroke_slope_estimator_core #(
    parameter int START_STRICTNESS = sse_pkg::DEFAULT_START_STRICTNESS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire sse_pkg::in_t s_payload,
    output logic              m_valid,
    input  wire logic         m_ready,
    output sse_pkg::out_t     m_payload
);

    sse_pkg::cmd_t    cmd;
    sse_pkg::status_t status;

    sse_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_last (s_payload.last_pair),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    sse_datapath #(
        .START_STRICTNESS (START_STRICTNESS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .m_ready   (m_ready),
        .status    (status),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("Result loaded while the output register was still full.");

    a_hold_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_payload.last_pair) |=> !s_ready)
        else $error("Input taken while a result was being computed.");

    a_step_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !cmd.accumulate && !cmd.load_div && !cmd.out_load)
        else $error("Divider step overlapped another datapath command.");

endmodule
`default_nettype wire

// File: design/sse_controller.sv
// Sequencing state machine of the stroke slope estimator.
`default_nettype none
module sse_controller (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            in_last,
    input  wire sse_pkg::status_t status,
    output logic                 s_ready,
    output sse_pkg::cmd_t        cmd
);

    sse_pkg::state_t state_reg;
    sse_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sse_pkg::ST_ACCUM;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sse_pkg::ST_ACCUM: begin
                if (s_valid && in_last) begin
                    state_next = sse_pkg::ST_SELECT;
                end
            end
            sse_pkg::ST_SELECT: begin
                state_next = sse_pkg::ST_DIVIDE;
            end
            sse_pkg::ST_DIVIDE: begin
                if (status.div_last) begin
                    state_next = sse_pkg::ST_DELIVER;
                end
            end
            sse_pkg::ST_DELIVER: begin
                if (status.out_free) begin
                    state_next = sse_pkg::ST_ACCUM;
                end
            end
            default: begin
                state_next = sse_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            sse_pkg::ST_ACCUM: begin
                s_ready = 1'b1;
                cmd.accumulate = s_valid;
            end
            sse_pkg::ST_SELECT: begin
                cmd.load_div = 1'b1;
            end
            sse_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            sse_pkg::ST_DELIVER: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/sse_datapath.sv
// Accumulator sets, set selection, serial divider and output register.
`default_nettype none
module sse_datapath #(
    parameter int START_STRICTNESS = sse_pkg::DEFAULT_START_STRICTNESS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sse_pkg::in_t    s_payload,
    input  wire sse_pkg::cmd_t   cmd,
    input  wire logic            m_ready,
    output sse_pkg::status_t     status,
    output logic                 m_valid,
    output sse_pkg::out_t        m_payload
);

    localparam int SET_COUNT = START_STRICTNESS + 1;
    localparam int SEL_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SW = sse_pkg::SUM_W;
    localparam int CW = sse_pkg::COORD_W;
    localparam int DW = sse_pkg::DIVIDEND_W;
    localparam int PW = DW + 1;
    localparam int NW = sse_pkg::COUNT_W;

    logic signed [SW-1:0] acc_dx_reg [SET_COUNT];
    logic signed [SW-1:0] acc_dy_reg [SET_COUNT];
    logic signed [SW-1:0] ref_dy_reg [SET_COUNT];

    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy;
    logic [CW-1:0]        adx;
    logic                 dy_pos;
    logic                 pair_ok;
    logic [SET_COUNT-1:0] lane_take;

    assign dx = SW'({1'b0, s_payload.first_end_x}) - SW'({1'b0, s_payload.second_begin_x});
    assign dy = SW'({1'b0, s_payload.second_begin_y}) - SW'({1'b0, s_payload.first_end_y});
    assign adx = CW'(dx[SW-1] ? -dx : dx);
    assign dy_pos = !dy[SW-1] && (dy != '0);
    assign pair_ok = s_payload.first_is_min && s_payload.second_is_max;

    logic signed [SW+1:0] ref4 [SET_COUNT];
    logic signed [SW+1:0] acc3 [SET_COUNT];

    for (genvar c = 0; c < SET_COUNT; c++) begin : g_lane
        assign lane_take[c] = dy_pos && ((18'(c) * 18'(adx)) < 18'(dy[CW-1:0]));
        assign ref4[c] = $signed(18'(ref_dy_reg[c])) <<< 2;
        assign acc3[c] = ($signed(18'(acc_dy_reg[c])) <<< 1) + $signed(18'(acc_dy_reg[c]));

        always_ff @(posedge aclk) begin
            if (!aresetn || cmd.load_div) begin
                acc_dx_reg[c] <= '0;
                acc_dy_reg[c] <= '0;
                ref_dy_reg[c] <= '0;
            end else if (cmd.accumulate && pair_ok) begin
                if (lane_take[c]) begin
                    acc_dx_reg[c] <= acc_dx_reg[c] + dx;
                    acc_dy_reg[c] <= acc_dy_reg[c] + dy;
                end else begin
                    ref_dy_reg[c] <= ref_dy_reg[c] + dy;
                end
            end
        end
    end

    logic [SEL_W-1:0]     sel;
    logic [2:0]           sel_ext;
    logic signed [SW-1:0] sel_dx;
    logic signed [SW-1:0] sel_dy;
    logic signed [PW-1:0] prod;
    logic [DW-1:0]        prod_mag;
    logic [SW-1:0]        dvs_mag;

    always_comb begin
        sel = '0;
        for (int c = 1; c < SET_COUNT; c++) begin
            if (ref4[c] <= acc3[c]) begin
                sel = SEL_W'(c);
            end
        end
    end

    assign sel_ext = 3'(sel);
    assign sel_dx = acc_dx_reg[sel];
    assign sel_dy = acc_dy_reg[sel];
    assign prod = PW'(sel_dx) * PW'(sse_pkg::SLOPE_SCALE);
    assign prod_mag = DW'(prod[PW-1] ? -prod : prod);
    assign dvs_mag = SW'(sel_dy[SW-1] ? -sel_dy : sel_dy);

    logic [DW-1:0] dvd_reg;
    logic [SW-1:0] dvs_reg;
    logic [SW-1:0] rem_reg;
    logic          neg_reg;
    logic          zero_reg;
    logic [1:0]    strict_reg;
    logic [NW-1:0] cnt_reg;

    logic [SW:0]   shifted;
    logic [SW+1:0] diff;
    logic          borrow;

    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign diff = {1'b0, shifted} - {2'b00, dvs_reg};
    assign borrow = diff[SW+1];

    always_ff @(posedge aclk) begin
        if (cmd.load_div) begin
            dvd_reg <= prod_mag;
            dvs_reg <= dvs_mag;
            rem_reg <= '0;
            neg_reg <= prod[PW-1] ^ sel_dy[SW-1];
            zero_reg <= (sel_dy == '0);
            strict_reg <= sel_ext[1:0];
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[DW-2:0], !borrow};
            rem_reg <= borrow ? shifted[SW-1:0] : diff[SW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load_div) begin
            cnt_reg <= NW'(sse_pkg::DIV_STEPS);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - NW'(1);
        end
    end

    assign status.div_last = (cnt_reg == NW'(1));

    logic          m_valid_reg;
    sse_pkg::out_t m_payload_reg;

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (zero_reg) begin
                m_payload_reg.slope <= '0;
            end else if (neg_reg) begin
                m_payload_reg.slope <= SW'(-dvd_reg);
            end else begin
                m_payload_reg.slope <= SW'(dvd_reg);
            end
            m_payload_reg.strictness_used <= strict_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
`default_nettype wire

// File: tb/stroke_slope_checker.sv
// Checker that predicts every slope result of the stroke slope estimator and compares it.
module stroke_slope_checker #(
    parameter int TOP_STRICTNESS = sse_pkg::DEFAULT_START_STRICTNESS
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  sse_pkg::in_t  s_payload,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  sse_pkg::out_t m_payload,
    output int            fail_count,
    output int            outstanding
);
    import sse_pkg::*;

    localparam int SETS = TOP_STRICTNESS + 1;

    logic signed [SUM_W-1:0] gathered_dx [SETS];
    logic signed [SUM_W-1:0] gathered_dy [SETS];
    logic signed [SUM_W-1:0] refused_dy [SETS];
    out_t expected_slopes [$];

    always @(posedge aclk) begin
        int c;
        int dx;
        int dy;
        int adx;
        int pick;
        int sdx;
        int sdy;
        int quot;
        out_t want;
        out_t got;
        if (!aresetn) begin
            for (c = 0; c < SETS; c++) begin
                gathered_dx[c] = '0;
                gathered_dy[c] = '0;
                refused_dy[c] = '0;
            end
            expected_slopes.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_payload.first_is_min && s_payload.second_is_max) begin
                    dx = int'(s_payload.first_end_x) - int'(s_payload.second_begin_x);
                    dy = int'(s_payload.second_begin_y) - int'(s_payload.first_end_y);
                    adx = (dx < 0) ? -dx : dx;
                    for (c = 0; c < SETS; c++) begin
                        if (dy > 0 && c * adx < dy) begin
                            gathered_dx[c] = gathered_dx[c] + SUM_W'(dx);
                            gathered_dy[c] = gathered_dy[c] + SUM_W'(dy);
                        end else begin
                            refused_dy[c] = refused_dy[c] + SUM_W'(dy);
                        end
                    end
                end
                if (s_payload.last_pair) begin
                    pick = TOP_STRICTNESS;
                    while (pick > 0 &&
                           4 * int'(refused_dy[pick]) > 3 * int'(gathered_dy[pick])) begin
                        pick--;
                    end
                    sdx = int'(gathered_dx[pick]);
                    sdy = int'(gathered_dy[pick]);
                    quot = (sdy != 0) ? (SLOPE_SCALE * sdx) / sdy : 0;
                    want.slope = SUM_W'(quot);
                    want.strictness_used = 2'(pick);
                    expected_slopes.push_back(want);
                    for (c = 0; c < SETS; c++) begin
                        gathered_dx[c] = '0;
                        gathered_dy[c] = '0;
                        refused_dy[c] = '0;
                    end
                end
            end
            if (m_valid && m_ready) begin
                got = m_payload;
                if (expected_slopes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result transfer with nothing expected: slope %0d strictness %0d",
                                 $time, got.slope, got.strictness_used);
                    end
                end else begin
                    want = expected_slopes.pop_front();
                    if (got.slope !== want.slope ||
                        got.strictness_used !== want.strictness_used) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: expected slope %0d strictness %0d, got slope %0d strictness %0d",
                                     $time, want.slope, want.strictness_used,
                                     got.slope, got.strictness_used);
                        end
                    end
                end
            end
        end
        outstanding = expected_slopes.size();
    end

endmodule

// File: tb/stroke_slope_estimator_core_test.sv
// Testbench top of the stroke slope estimator: clock, reset, pair lists and verdict.
module stroke_slope_estimator_core_test;
    import sse_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;
    int   fail_count;
    int   outstanding;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stroke_slope_estimator_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    stroke_slope_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic in_t make_pair(input logic min_mark, input logic max_mark,
                                      input int ax, input int ay, input int bx, input int by,
                                      input logic last);
        in_t p;
        p.first_is_min = min_mark;
        p.second_is_max = max_mark;
        p.first_end_x = COORD_W'(ax);
        p.first_end_y = COORD_W'(ay);
        p.second_begin_x = COORD_W'(bx);
        p.second_begin_y = COORD_W'(by);
        p.last_pair = last;
        return p;
    endfunction

    function automatic in_t random_pair(input logic last);
        in_t p;
        int kind;
        int span;
        int rise;
        int run;
        int lo;
        p = make_pair(1'b1, 1'b1, $urandom_range(32767), $urandom_range(32767),
                      $urandom_range(32767), $urandom_range(32767), last);
        kind = $urandom_range(99);
        if (kind < 60) begin
            case ($urandom_range(2))
                0: span = 100;
                1: span = 3000;
                default: span = 32767;
            endcase
            rise = $urandom_range(1, span);
            run = $urandom_range(0, rise);
            if ($urandom_range(1) == 1) begin
                run = run / 3;
            end
            lo = $urandom_range(0, 32767 - rise);
            p.first_end_y = COORD_W'(lo);
            p.second_begin_y = COORD_W'(lo + rise);
            lo = $urandom_range(0, 32767 - run);
            if ($urandom_range(1) == 1) begin
                p.first_end_x = COORD_W'(lo + run);
                p.second_begin_x = COORD_W'(lo);
            end else begin
                p.first_end_x = COORD_W'(lo);
                p.second_begin_x = COORD_W'(lo + run);
            end
        end else if (kind < 75) begin
            p.first_is_min = 1'b1;
        end else if (kind < 85) begin
            p.second_begin_y = COORD_W'($urandom_range(0, int'(p.first_end_y)));
        end else begin
            case ($urandom_range(2))
                0: {p.first_is_min, p.second_is_max} = 2'b00;
                1: {p.first_is_min, p.second_is_max} = 2'b01;
                default: {p.first_is_min, p.second_is_max} = 2'b10;
            endcase
        end
        return p;
    endfunction

    task automatic send_pair(input in_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= p;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic run_lists(input int items);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
                send_pair(random_pair(i == len - 1));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 18;
        recv_idle_pct <= 81;

        send_pair(make_pair(1'b0, 1'b0, 0, 0, 0, 0, 1'b1));
        send_pair(make_pair(1'b1, 1'b0, 32767, 32767, 32767, 32767, 1'b1));
        send_pair(make_pair(1'b0, 1'b1, 123, 4000, 456, 100, 1'b0));
        send_pair(make_pair(1'b1, 1'b1, 100, 0, 100, 1000, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 32767, 0, 0, 32767, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 0, 32767, 32767, 0, 1'b1));
        // A tiny rise under a wide run overflows the scaled quotient.
        send_pair(make_pair(1'b1, 1'b1, 32767, 0, 0, 1, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 5, 0, 0, 32767, 1'b0));
        send_pair(make_pair(1'b1, 1'b1, 5, 0, 0, 32767, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 10, 0, 0, 100, 1'b0));
        send_pair(make_pair(1'b1, 1'b1, 60, 0, 0, 100, 1'b1));
        // Refused sum exactly three quarters of the accepted one keeps the strictest set.
        send_pair(make_pair(1'b1, 1'b1, 0, 0, 40, 400, 1'b0));
        send_pair(make_pair(1'b1, 1'b1, 200, 0, 0, 300, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 0, 10, 1, 13, 1'b1));
        send_pair(make_pair(1'b1, 1'b1, 50, 500, 0, 500, 1'b0));
        send_pair(make_pair(1'b1, 1'b1, 3, 0, 0, 200, 1'b0));
        send_pair(make_pair(1'b0, 1'b0, 32767, 0, 32767, 0, 1'b1));

        run_lists(370);
        send_idle_pct = 81;
        recv_idle_pct <= 18;
        run_lists(380);
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_lists(380);
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
design/sse_pkg.sv
design/sse_controller.sv
design/sse_datapath.sv
design/stroke_slope_estimator_core.sv
tb/stroke_slope_checker.sv
tb/stroke_slope_estimator_core_test.sv
